// ===== hdl/price_level_order_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the price level order queue
// Immediate-style wrappers around concurrent properties; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_QUEUE_MACROS_SVH
`define PRICE_LEVEL_ORDER_QUEUE_MACROS_SVH
`ifndef SYNTH
`define PLOQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plo assertion failed");
`define PLOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plo assertion failed");
`else
`define PLOQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PLOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/plo_pkg.sv =====
// ----------------------------------------------------------------------------
// plo_pkg
// Shared sizes, codes and controller/datapath types of the price level queue.
// ----------------------------------------------------------------------------
package plo_pkg;

	localparam int SLOTS  = 64;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int SCAN_W = $clog2(SLOTS + 1);
	localparam int RC_W   = $clog2(SLOTS + 1);

	localparam int OP_W  = 2;
	localparam int ID_W  = 31;
	localparam int SH_W  = 32;
	localparam int ST_W  = 3;
	localparam int CNT_W = 7;
	localparam int VOL_W = 38;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_DUP       = 3'd4
	} status_t;

	typedef struct packed {
		logic    accept;
		logic    scan_start;
		logic    scan_run;
		logic    tgt_head;
		logic    tgt_hit;
		logic    read_tgt;
		logic    unlink;
		logic    append;
		logic    set_status;
		status_t status;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            scan_done;
		logic            found;
		logic            free_found;
		logic            empty;
	} stat_t;

endpackage

// ===== hdl/plo_req_if.sv =====
// ----------------------------------------------------------------------------
// plo_req_if
// Request channel: one order operation word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface plo_req_if import plo_pkg::*; ();

	logic            valid;
	logic            ready;
	logic [OP_W-1:0] operation;
	logic [ID_W-1:0] order_id;
	logic [SH_W-1:0] shares;

	modport source(output valid, operation, order_id, shares, input ready);
	modport sink(input valid, operation, order_id, shares, output ready);

endinterface

// ===== hdl/plo_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plo_rsp_if
// Response channel: one result word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface plo_rsp_if import plo_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic             popped_valid;
	logic [ID_W-1:0]  popped_id;
	logic [SH_W-1:0]  popped_shares;
	logic [CNT_W-1:0] order_count;
	logic [VOL_W-1:0] level_volume;

	modport source(output valid, status, popped_valid, popped_id, popped_shares,
		order_count, level_volume, input ready);
	modport sink(input valid, status, popped_valid, popped_id, popped_shares,
		order_count, level_volume, output ready);

endinterface

// ===== hdl/plo_dpath.sv =====
// ----------------------------------------------------------------------------
// plo_dpath
// Slot table, linked list pointers, id scan, count/volume and result register.
// ----------------------------------------------------------------------------
`include "price_level_order_queue_macros.svh"

module plo_dpath import plo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic [OP_W-1:0]  operation,
	input  logic [ID_W-1:0]  order_id,
	input  logic [SH_W-1:0]  shares,
	output logic [ST_W-1:0]  status,
	output logic             popped_valid,
	output logic [ID_W-1:0]  popped_id,
	output logic [SH_W-1:0]  popped_shares,
	output logic [CNT_W-1:0] order_count,
	output logic [VOL_W-1:0] level_volume
);

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [SH_W-1:0] sh;
	} entry_t;

	entry_t           data_mem [SLOTS];
	logic [IDX_W-1:0] next_mem [SLOTS];
	logic [IDX_W-1:0] prev_mem [SLOTS];

	entry_t           data_rd_q;
	logic [IDX_W-1:0] next_rd_q;
	logic [IDX_W-1:0] prev_rd_q;

	logic [OP_W-1:0]  op_q;
	logic [ID_W-1:0]  id_q;
	logic [SH_W-1:0]  sh_q;

	logic [SLOTS-1:0] valid_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [RC_W-1:0]  count_q;
	logic [VOL_W-1:0] volume_q;

	logic [SCAN_W-1:0] scan_cnt_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              found_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  hit_q;
	logic [IDX_W-1:0]  free_q;
	logic [IDX_W-1:0]  tgt_q;

	status_t          status_q;
	logic             pop_v_q;
	logic [ID_W-1:0]  pop_id_q;
	logic [SH_W-1:0]  pop_sh_q;

	logic [ST_W-1:0]  status_out_q;
	logic             pop_v_out_q;
	logic [ID_W-1:0]  pop_id_out_q;
	logic [SH_W-1:0]  pop_sh_out_q;
	logic [CNT_W-1:0] count_out_q;
	logic [VOL_W-1:0] volume_out_q;

	logic             scan_end;
	logic             scan_issue;
	logic [IDX_W-1:0] rd_addr;
	logic             hit;
	logic             is_head;
	logic             is_tail;
	logic             next_we;
	logic [IDX_W-1:0] next_wa;
	logic [IDX_W-1:0] next_wd;
	logic             prev_we;
	logic [IDX_W-1:0] prev_wa;
	logic [IDX_W-1:0] prev_wd;

	assign scan_end   = (scan_cnt_q == SCAN_W'(SLOTS));
	assign scan_issue = cmd.scan_run && !scan_end;
	assign rd_addr    = cmd.read_tgt ? tgt_q : scan_cnt_q[IDX_W-1:0];
	assign hit        = pend_s1 && valid_q[idx_s1] && (data_rd_q.id == id_q);
	assign is_head    = (tgt_q == head_q);
	assign is_tail    = (tgt_q == tail_q);

	always_comb begin
		next_we = 1'b0;
		next_wa = tail_q;
		next_wd = free_q;
		prev_we = 1'b0;
		prev_wa = free_q;
		prev_wd = tail_q;
		if (cmd.append) begin
			next_we = (count_q != '0);
			prev_we = 1'b1;
		end else if (cmd.unlink) begin
			next_we = !is_head;
			next_wa = prev_rd_q;
			next_wd = next_rd_q;
			prev_we = !is_tail;
			prev_wa = next_rd_q;
			prev_wd = prev_rd_q;
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		data_rd_q <= data_mem[rd_addr];
		next_rd_q <= next_mem[rd_addr];
		prev_rd_q <= prev_mem[rd_addr];
		if (cmd.append) begin
			data_mem[free_q] <= '{id: id_q, sh: sh_q};
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= operation;
			id_q <= order_id;
			sh_q <= shares;
		end
		if (cmd.scan_run) begin
			idx_s1 <= scan_cnt_q[IDX_W-1:0];
		end
		if (cmd.scan_run && hit && !found_q) begin
			hit_q <= idx_s1;
		end
		if (cmd.scan_run && pend_s1 && !valid_q[idx_s1] && !free_found_q) begin
			free_q <= idx_s1;
		end
		if (cmd.tgt_head) begin
			tgt_q <= head_q;
		end else if (cmd.tgt_hit) begin
			tgt_q <= hit_q;
		end
		if (cmd.accept) begin
			pop_id_q <= '0;
			pop_sh_q <= '0;
		end else if (cmd.unlink && op_q == OP_POP) begin
			pop_id_q <= data_rd_q.id;
			pop_sh_q <= data_rd_q.sh;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.load_out) begin
			status_out_q <= status_q;
			pop_v_out_q  <= pop_v_q;
			pop_id_out_q <= pop_id_q;
			pop_sh_out_q <= pop_sh_q;
			count_out_q  <= CNT_W'(count_q);
			volume_out_q <= volume_q;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q   <= '0;
			pend_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			pop_v_q      <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_cnt_q   <= '0;
				pend_s1      <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan_run) begin
				if (scan_issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				pend_s1 <= scan_issue;
				if (hit) begin
					found_q <= 1'b1;
				end
				if (pend_s1 && !valid_q[idx_s1]) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.accept) begin
				pop_v_q <= 1'b0;
			end else if (cmd.unlink && op_q == OP_POP) begin
				pop_v_q <= 1'b1;
			end
		end
	end

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			volume_q <= '0;
		end else if (cmd.append) begin
			valid_q[free_q] <= 1'b1;
			if (count_q == '0) begin
				head_q <= free_q;
			end
			tail_q   <= free_q;
			count_q  <= count_q + 1'b1;
			volume_q <= volume_q + VOL_W'(sh_q);
		end else if (cmd.unlink) begin
			valid_q[tgt_q] <= 1'b0;
			if (count_q == RC_W'(1)) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (is_head) begin
					head_q <= next_rd_q;
				end
				if (is_tail) begin
					tail_q <= prev_rd_q;
				end
			end
			if (count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
			volume_q <= volume_q - VOL_W'(data_rd_q.sh);
		end
	end

	assign stat.op         = op_q;
	assign stat.scan_done  = found_q || (scan_end && !pend_s1);
	assign stat.found      = found_q;
	assign stat.free_found = free_found_q;
	assign stat.empty      = (count_q == '0);

	assign status        = status_out_q;
	assign popped_valid  = pop_v_out_q;
	assign popped_id     = pop_id_out_q;
	assign popped_shares = pop_sh_out_q;
	assign order_count   = count_out_q;
	assign level_volume  = volume_out_q;

	`PLOQ_ASSERT_SAME(a_append_free, clk, arst_n, cmd.append, !valid_q[free_q])
	`PLOQ_ASSERT_SAME(a_unlink_live, clk, arst_n, cmd.unlink, valid_q[tgt_q])
	`PLOQ_ASSERT_SAME(a_count_bits, clk, arst_n, 1'b1, $countones(valid_q) == int'(count_q))

endmodule

// ===== hdl/plo_ctrl.sv =====
// ----------------------------------------------------------------------------
// plo_ctrl
// Operation sequencer: decode, id scan, slot lookup, link update, response.
// ----------------------------------------------------------------------------
`include "price_level_order_queue_macros.svh"

module plo_ctrl import plo_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_LOOKUP = 7'b0001000,
		S_UNLINK = 7'b0010000,
		S_APPEND = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				cmd.status     = ST_OK;
				priority if (stat.op == OP_ADD || stat.op == OP_CANCEL) begin
					cmd.scan_start = 1'b1;
					state_nx       = S_SCAN;
				end else if (stat.op == OP_POP) begin
					if (stat.empty) begin
						cmd.status = ST_EMPTY;
						state_nx   = S_RESP;
					end else begin
						cmd.tgt_head = 1'b1;
						state_nx     = S_LOOKUP;
					end
				end else begin
					state_nx = S_RESP;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					priority if (stat.op == OP_ADD) begin
						if (stat.found) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_DUP;
							state_nx       = S_RESP;
						end else if (!stat.free_found) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
							state_nx       = S_RESP;
						end else begin
							state_nx = S_APPEND;
						end
					end else if (stat.found) begin
						cmd.tgt_hit = 1'b1;
						state_nx    = S_LOOKUP;
					end else begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_NOT_FOUND;
						state_nx       = S_RESP;
					end
				end
			end
			S_LOOKUP: begin
				cmd.read_tgt = 1'b1;
				state_nx     = S_UNLINK;
			end
			S_UNLINK: begin
				cmd.unlink = 1'b1;
				state_nx   = S_RESP;
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_nx   = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`PLOQ_ASSERT_NEXT(a_accept_decode, clk, arst_n, req_valid && req_ready, state_q == S_DECODE)
	`PLOQ_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load_out, rsp_valid_q && state_q == S_IDLE)

endmodule

// ===== hdl/price_level_order_queue.sv =====
// ----------------------------------------------------------------------------
// price_level_order_queue
// One price level of an order book: time-ordered queue of resting orders.
// Flow: add and cancel scan the slot ids first, and the id scan reads one slot per
//   cycle; pop, pop on empty and op code 3 skip the scan.
// Flow control: one word at a time; a new request is taken while a result waits.
// Reset: arst_n clears the queue to empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module price_level_order_queue import plo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	plo_req_if.sink   req,
	plo_rsp_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;

	plo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	plo_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (req.operation),
		.order_id      (req.order_id),
		.shares        (req.shares),
		.status        (rsp.status),
		.popped_valid  (rsp.popped_valid),
		.popped_id     (rsp.popped_id),
		.popped_shares (rsp.popped_shares),
		.order_count   (rsp.order_count),
		.level_volume  (rsp.level_volume)
	);

endmodule
